FILE: design/lzbd_pkg.sv
// Shared constants and types for the LZ back-reference decompressor.
package lzbd_pkg;

  localparam int WIN_DEPTH  = 4096;
  localparam int WIN_AW     = $clog2(WIN_DEPTH);
  localparam int CNT_W      = 24;
  localparam int CFG_W      = 24;
  localparam int LEN_W      = 5;
  localparam int DIST_W     = WIN_AW + 1;
  localparam int LEN_OFFSET = 3;
  localparam logic [7:0] LEN_MASK  = 8'hF0;
  localparam logic [7:0] DIST_MASK = 8'h0F;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic              new_block;
    logic              lit;
    logic [7:0]        lit_byte;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] back_dist;
  } token_t;

endpackage

FILE: design/lzbd_if.sv
// Valid/ready channel interfaces for tokens in and bytes out.
interface lzbd_in_if;
  logic       valid;
  logic       ready;
  logic       new_block;
  logic       is_literal;
  logic [7:0] literal_byte;
  logic [7:0] pair_high;
  logic [7:0] pair_low;

  modport source (output valid, new_block, is_literal, literal_byte, pair_high, pair_low,
                  input ready);
  modport sink   (input valid, new_block, is_literal, literal_byte, pair_high, pair_low,
                  output ready);
endinterface

interface lzbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_of_output;
  logic       reference_error;

  modport source (output valid, out_byte, last_of_run, end_of_output, reference_error,
                  input ready);
  modport sink   (input valid, out_byte, last_of_run, end_of_output, reference_error,
                  output ready);
endinterface

FILE: design/lzbd_front.sv
// Front end: accepts tokens and decodes length and distance.
module lzbd_front (
  lzbd_in_if.sink          in_if,
  output lzbd_pkg::token_t tok_o,
  output logic             tok_valid_o,
  input  logic             tok_ready_i
);
  import lzbd_pkg::*;

  logic [3:0] len_nib;
  logic [3:0] dist_nib;

  assign len_nib  = 4'((in_if.pair_high & LEN_MASK) >> 4);
  assign dist_nib = 4'(in_if.pair_high & DIST_MASK);

  always_comb begin
    tok_o.new_block = in_if.new_block;
    tok_o.lit       = in_if.is_literal;
    tok_o.lit_byte  = in_if.literal_byte;
    if (in_if.is_literal) begin
      tok_o.len       = LEN_W'(1);
      tok_o.back_dist = '0;
    end else begin
      tok_o.len       = LEN_W'(len_nib) + LEN_W'(LEN_OFFSET);
      tok_o.back_dist = {1'b0, dist_nib, in_if.pair_low} + DIST_W'(1);
    end
  end

  assign tok_valid_o  = in_if.valid;
  assign in_if.ready  = tok_ready_i;

endmodule

FILE: design/lzbd_fifo.sv
// Two-entry token queue between front and back.
module lzbd_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lzbd_pkg::token_t wr_tok_i,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  output lzbd_pkg::token_t rd_tok_o,
  output logic             rd_valid_o,
  input  logic             rd_ready_i
);
  import lzbd_pkg::*;

  token_t     mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_tok_o   = mem_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_tok_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: design/lzbd_back.sv
// Back end: run sequencer, history window and output register.
module lzbd_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lzbd_pkg::CFG_W-1:0]     cfg_data_i,
  input  lzbd_pkg::token_t               tok_i,
  input  logic                           tok_valid_i,
  output logic                           tok_ready_o,
  lzbd_out_if.source                     out_if
);
  import lzbd_pkg::*;

  logic [CFG_W-1:0]  olen_q;
  logic [CNT_W-1:0]  cnt_q, cnt_inc;
  logic [WIN_AW-1:0] pos_q, rd_addr;
  logic              act_q;
  logic              t_lit_q;
  logic [7:0]        t_byte_q;
  logic [DIST_W-1:0] t_dist_q;
  logic [LEN_W-1:0]  rem_q;

  logic              ld, stop, iss, iss_ok, i_end, i_last, i_err;

  logic [7:0]        win [WIN_DEPTH];
  logic [7:0]        rd_q;
  logic              b_vld_q, b_lit_q, b_last_q, b_end_q, b_err_q, b_hit_q;
  logic [7:0]        b_lbyte_q, b_hitd_q, b_byte;
  logic [WIN_AW-1:0] b_addr_q;
  logic              b_adv;

  logic              o_vld_q, o_last_q, o_end_q, o_err_q;
  logic [7:0]        o_byte_q;

  assign ld          = !act_q && tok_valid_i;
  assign tok_ready_o = !act_q;

  assign stop    = (cnt_q >= olen_q) || (cnt_q == CNT_MAX);
  assign b_adv   = b_vld_q && (!o_vld_q || out_if.ready);
  assign iss_ok  = !b_vld_q || b_adv;
  assign iss     = act_q && !stop && iss_ok;
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign i_end   = (cnt_inc == olen_q);
  assign i_last  = (rem_q == LEN_W'(1)) || i_end || (cnt_inc == CNT_MAX);
  assign i_err   = !t_lit_q && (CNT_W'(t_dist_q) > cnt_q);
  assign rd_addr = pos_q - WIN_AW'(t_dist_q);

  assign b_byte = b_lit_q ? b_lbyte_q : (b_err_q ? 8'h00 : (b_hit_q ? b_hitd_q : rd_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      olen_q <= '0;
      cnt_q  <= '0;
      pos_q  <= '0;
      act_q  <= 1'b0;
    end else begin
      if (cfg_we_i) olen_q <= cfg_data_i;
      if (ld) begin
        act_q <= 1'b1;
        if (tok_i.new_block) begin
          cnt_q <= '0;
          pos_q <= '0;
        end
      end else if (iss) begin
        cnt_q <= cnt_inc;
        pos_q <= pos_q + WIN_AW'(1);
        if (i_last) act_q <= 1'b0;
      end else if (act_q && stop) begin
        act_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      t_lit_q  <= tok_i.lit;
      t_byte_q <= tok_i.lit_byte;
      t_dist_q <= tok_i.back_dist;
      rem_q    <= tok_i.len;
    end else if (iss) begin
      rem_q <= rem_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) win[b_addr_q] <= b_byte;
    if (iss)   rd_q <= win[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (iss) begin
      b_lit_q   <= t_lit_q;
      b_lbyte_q <= t_byte_q;
      b_last_q  <= i_last;
      b_end_q   <= i_end;
      b_err_q   <= i_err;
      b_addr_q  <= pos_q;
      b_hit_q   <= b_adv && (b_addr_q == rd_addr);
      b_hitd_q  <= b_byte;
    end
    if (b_adv) begin
      o_byte_q <= b_byte;
      o_last_q <= b_last_q;
      o_end_q  <= b_end_q;
      o_err_q  <= b_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (iss)        b_vld_q <= 1'b1;
      else if (b_adv) b_vld_q <= 1'b0;
      if (b_adv)             o_vld_q <= 1'b1;
      else if (out_if.ready) o_vld_q <= 1'b0;
    end
  end

  assign out_if.valid           = o_vld_q;
  assign out_if.out_byte        = o_byte_q;
  assign out_if.last_of_run     = o_last_q;
  assign out_if.end_of_output   = o_end_q;
  assign out_if.reference_error = o_err_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q && o_end_q |-> o_last_q) else $error("end of output without last of run");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q && o_err_q |-> (o_byte_q == 8'h00)) else $error("reference error with nonzero byte");

  a_issue_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss |=> b_vld_q) else $error("issued byte lost before stage two");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld |=> act_q) else $error("token load did not start a run");

endmodule

FILE: design/lz_backreference_decompressor.sv
// Top level of the LZ back-reference decompressor.
//
//   port        dir   handshake        carries
//   in_if       in    valid/ready      one token: literal byte or reference pair
//   out_if      out   valid/ready      one decompressed byte with run/end/error flags
//   cfg_we_i    in    write enable     output_length register
//
// A literal token gives at most one byte, a reference token at most len bytes (3 to 18),
// with the run sequencer issuing one window read per byte.
// Window reads are registered; a same-cycle write is forwarded to the read.
// Reset clears counters and control; the history window is not cleared.
// Output stalls back up through a two-stage byte pipe into the token queue.
module lz_backreference_decompressor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lzbd_pkg::CFG_W-1:0] cfg_data_i,
  lzbd_in_if.sink                    in_if,
  lzbd_out_if.source                 out_if
);
  import lzbd_pkg::*;

  token_t f_tok, q_tok;
  logic   f_valid, f_ready, q_valid, q_ready;

  lzbd_front u_front (
    .in_if       (in_if),
    .tok_o       (f_tok),
    .tok_valid_o (f_valid),
    .tok_ready_i (f_ready)
  );

  lzbd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_tok_i   (f_tok),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .rd_tok_o   (q_tok),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready)
  );

  lzbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .tok_i       (q_tok),
    .tok_valid_i (q_valid),
    .tok_ready_o (q_ready),
    .out_if      (out_if)
  );

endmodule

FILE: verif/tb_lz_backreference_decompressor.sv
// Testbench for the LZ back-reference decompressor: directed and random token streams checked byte by byte.
module tb_lz_backreference_decompressor;
  timeunit 1ns;
  timeprecision 1ps;
  import lzbd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eoo;
    logic       err;
  } dec_byte_t;

  class decode_tracker;
    logic [7:0]        history [WIN_DEPTH];
    logic [WIN_AW-1:0] wpos;
    logic [CNT_W-1:0]  written;
    logic [CFG_W-1:0]  out_len;
    dec_byte_t         expected_bytes[$];
    int                failures;

    function new();
      wpos     = '0;
      written  = '0;
      out_len  = '0;
      failures = 0;
    endfunction

    function void take_token(logic nb, logic lit, logic [7:0] lb, logic [7:0] ph,
                             logic [7:0] pl);
      int unsigned       run_len;
      int unsigned       back_dist;
      logic [WIN_AW-1:0] src;
      dec_byte_t         b;
      if (nb) begin
        written = '0;
        wpos    = '0;
      end
      if (lit) begin
        run_len   = 1;
        back_dist = 0;
      end else begin
        run_len   = ((ph & LEN_MASK) >> 4) + LEN_OFFSET;
        back_dist = {(ph & DIST_MASK), pl} + 1;
      end
      for (int unsigned i = 0; i < run_len; i++) begin
        if (written >= out_len || written >= CNT_MAX) break;
        b.err = 1'b0;
        if (lit) begin
          b.data = lb;
        end else if (back_dist > written) begin
          b.data = 8'h00;
          b.err  = 1'b1;
        end else begin
          src    = wpos - WIN_AW'(back_dist);
          b.data = history[src];
        end
        history[wpos] = b.data;
        wpos          = wpos + 1'b1;
        written       = written + 1'b1;
        b.eoo         = (written == out_len);
        b.last        = (i + 1 == run_len) || b.eoo || (written >= CNT_MAX);
        expected_bytes.push_back(b);
      end
    endfunction

    function void check_byte(dec_byte_t got);
      dec_byte_t want;
      if (expected_bytes.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected byte: data=%02h last=%b end=%b err=%b",
                   got.data, got.last, got.eoo, got.err);
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("byte mismatch: exp data=%02h last=%b end=%b err=%b, got data=%02h last=%b end=%b err=%b",
                   want.data, want.last, want.eoo, want.err,
                   got.data, got.last, got.eoo, got.err);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_data_i;

  lzbd_in_if  in_if ();
  lzbd_out_if out_if ();

  lz_backreference_decompressor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  decode_tracker tracker = new();
  int            src_calm = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side: stretches of steady ready mixed with random stalls
  initial begin
    int calm_left;
    int hold;
    bit stall_mode;
    calm_left  = 0;
    hold       = 0;
    stall_mode = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (calm_left == 0) begin
        stall_mode = ($urandom_range(0, 2) != 0);
        calm_left  = $urandom_range(20, 200);
      end
      calm_left--;
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if (stall_mode && $urandom_range(0, 2) == 0) begin
        hold = pick_gap();
        if (hold > 0) begin
          hold--;
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      tracker.check_byte({out_if.out_byte, out_if.last_of_run, out_if.end_of_output,
                          out_if.reference_error});
  end

  task automatic send_token(input logic nb, input logic lit, input logic [7:0] lb,
                            input logic [7:0] ph, input logic [7:0] pl);
    int gap;
    in_if.valid        <= 1'b1;
    in_if.new_block    <= nb;
    in_if.is_literal   <= lit;
    in_if.literal_byte <= lb;
    in_if.pair_high    <= ph;
    in_if.pair_low     <= pl;
    do @(posedge clk_i); while (!in_if.ready);
    tracker.take_token(nb, lit, lb, ph, pl);
    if (src_calm > 0) begin
      src_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0) src_calm = $urandom_range(10, 40);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input bit long_runs, input bit allow_nb);
    logic        nb;
    logic        lit;
    logic [11:0] dm1;
    logic [3:0]  nib;
    logic [7:0]  ph;
    logic [7:0]  pl;
    int unsigned reach;
    int unsigned d;
    int          r;
    nb    = allow_nb && ($urandom_range(0, 49) == 0);
    lit   = long_runs ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 3) == 0);
    reach = nb ? 0 : tracker.written;
    if (reach > WIN_DEPTH) reach = WIN_DEPTH;
    r = $urandom_range(0, 9);
    if (reach == 0 || r == 0) d = $urandom_range(1, WIN_DEPTH);
    else if (r == 1) d = 1;
    else if (r == 2) d = reach;
    else d = $urandom_range(1, reach);
    dm1 = 12'(d - 1);
    nib = (long_runs && $urandom_range(0, 9) != 0) ? 4'hF : 4'($urandom_range(0, 15));
    ph  = {nib, dm1[11:8]};
    pl  = dm1[7:0];
    if (lit) begin
      ph = 8'($urandom);
      pl = 8'($urandom);
    end
    send_token(nb, lit, 8'($urandom), ph, pl);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] v);
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.out_len = v;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (tracker.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_data_i         <= '0;
    in_if.valid        <= 1'b0;
    in_if.new_block    <= 1'b0;
    in_if.is_literal   <= 1'b0;
    in_if.literal_byte <= '0;
    in_if.pair_high    <= '0;
    in_if.pair_low     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // length still zero after reset: nothing comes out
    send_token(1'b1, 1'b1, 8'hFF, 8'h00, 8'h00);
    send_token(1'b0, 1'b0, 8'h00, 8'hFF, 8'hFF);
    drain();

    write_length(24'hFFFFFF);
    send_token(1'b1, 1'b1, 8'h00, 8'hFF, 8'hFF);
    send_token(1'b0, 1'b1, 8'hFF, 8'h00, 8'h00);
    send_token(1'b0, 1'b0, 8'hFF, 8'h00, 8'h00);  // overlapping copy, distance 1
    send_token(1'b0, 1'b0, 8'h00, 8'h01, 8'h00);  // reaches before block start
    send_token(1'b0, 1'b0, 8'h5A, 8'hF0, 8'h07);  // distance equals bytes so far
    send_token(1'b0, 1'b0, 8'h00, 8'hFF, 8'hFF);  // distance 4096, too far back
    send_token(1'b0, 1'b0, 8'hC3, 8'h5A, 8'hA5);
    send_token(1'b1, 1'b1, 8'h5A, 8'h00, 8'h01);
    send_token(1'b0, 1'b0, 8'h00, 8'h00, 8'h01);
    drain();

    // run cut short by the length, a token past the end, then a new block
    write_length(24'd10);
    send_token(1'b1, 1'b1, 8'hA5, 8'h00, 8'h00);
    send_token(1'b0, 1'b0, 8'h00, 8'hF0, 8'h00);
    send_token(1'b0, 1'b1, 8'h33, 8'h00, 8'h00);
    send_token(1'b1, 1'b0, 8'h00, 8'h30, 8'h00);
    send_token(1'b0, 1'b1, 8'h11, 8'hFF, 8'hFF);
    drain();

    // length lowered below the bytes already written
    write_length(24'd3);
    send_token(1'b0, 1'b1, 8'h22, 8'h00, 8'h00);
    send_token(1'b0, 1'b0, 8'h00, 8'h10, 8'h00);
    drain();

    write_length(24'd1);
    send_token(1'b1, 1'b1, 8'hC3, 8'h00, 8'h00);
    send_token(1'b1, 1'b0, 8'h00, 8'h20, 8'h00);
    drain();

    repeat (3) begin
      write_length(CFG_W'($urandom_range(1, 150)));
      send_random(1'b0, 1'b0);
      while (tracker.written < tracker.out_len) send_random(1'b0, 1'b1);
      send_random(1'b0, 1'b0);
      send_random(1'b0, 1'b1);
      drain();
    end

    // long block so the window wraps and far references hit real data
    write_length(CFG_W'($urandom_range(4150, 4350)));
    send_token(1'b1, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
    while (tracker.written < tracker.out_len) send_random(1'b1, 1'b0);
    send_random(1'b1, 1'b0);
    drain();

    if (tracker.failures == 0 && tracker.expected_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lzbd_pkg.sv
design/lzbd_if.sv
design/lzbd_front.sv
design/lzbd_fifo.sv
design/lzbd_back.sv
design/lz_backreference_decompressor.sv
verif/tb_lz_backreference_decompressor.sv
